// ===== hw/rtl/plc_pkg.sv =====
`default_nettype none

package plc_pkg;

    // Request actions as they arrive on the action field.
    typedef enum logic [2:0] {
        ACT_ADD_FRONT    = 3'd0,
        ACT_ADD_REAR     = 3'd1,
        ACT_REMOVE_FRONT = 3'd2,
        ACT_REMOVE_REAR  = 3'd3,
        ACT_INSERT_AT    = 3'd4,
        ACT_REMOVE_AT    = 3'd5
    } action_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_RANGE = 2'd2,
        ST_OVER  = 2'd3
    } status_t;

    localparam int ACTION_W   = 3;
    localparam int POSITION_W = 7;
    localparam int VALUE_W    = 32;
    localparam int LENGTH_W   = 7;

    // Shift command broadcast to every cell of the row.
    typedef struct packed {
        logic shift_ins;  // open a hole at the index and write the new element there
        logic shift_del;  // close the gap at the index, later cells move toward the front
    } ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/plc_cell.sv =====
`default_nettype none

module plc_cell #(
    parameter int ELEM_WIDTH = 32,
    parameter int IDX_W      = 6,
    parameter int CELL_INDEX = 0
) (
    input  wire                   clk,
    input  wire plc_pkg::ctl_t    ctl,
    input  wire [IDX_W-1:0]       idx,
    input  wire [ELEM_WIDTH-1:0]  new_elem,
    input  wire [ELEM_WIDTH-1:0]  left_data,
    input  wire [ELEM_WIDTH-1:0]  right_data,
    output logic [ELEM_WIDTH-1:0] data,
    output logic [ELEM_WIDTH-1:0] tap
);
    import plc_pkg::*;

    localparam logic [IDX_W:0] MY_INDEX = (IDX_W + 1)'(CELL_INDEX);

    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] data_next;
    logic                  at_idx;
    logic                  after_idx;

    assign at_idx    = ({1'b0, idx} == MY_INDEX);
    assign after_idx = (MY_INDEX > {1'b0, idx});

    // Each cell either holds, takes its front neighbor, takes its rear
    // neighbor, or takes the incoming element.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift_ins)
        begin
            if (after_idx)
            begin
                data_next = left_data;
            end
            else if (at_idx)
            begin
                data_next = new_elem;
            end
        end
        else if (ctl.shift_del && (after_idx || at_idx))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // The element leaving the row shows up on this cell's tap only.
    assign tap  = (ctl.shift_del && at_idx) ? data_reg : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/positional_list_store.sv =====
`default_nettype none

// Bounded ordered list of up to CAPACITY elements held in a row of cells,
// one element per cell with the front of the list in cell zero. A request
// adds or removes at the front, the rear or a 1-based position; every
// accepted request returns one result beat carrying the removed element
// (zero unless a removal succeeded), a status and the count afterwards.
// All cells shift in the same clock, so a request is applied at the edge
// that accepts it, and its result enters the output register at that edge.
// A new request is taken whenever the output register is empty or
// is being drained, so the block sustains one beat per cycle as long as
// the consumer keeps out_ready high. Elements in cells at or beyond the
// count are never returned, so the row needs no clearing after reset.
module positional_list_store #(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  [plc_pkg::ACTION_W-1:0]      action,
    input  wire  [plc_pkg::POSITION_W-1:0]    position,
    input  wire  [plc_pkg::VALUE_W-1:0]       value,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [plc_pkg::VALUE_W-1:0]       removed_value,
    output logic [1:0]                        status,
    output logic [plc_pkg::LENGTH_W-1:0]      length
);
    import plc_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Compare width holds count+1 and any position without wrapping.
    localparam int CMP_W = ((CNT_W > POSITION_W) ? CNT_W : POSITION_W) + 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Control and count state.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    // Result register.
    logic [VALUE_W-1:0]    removed_reg;
    status_t               status_reg;
    status_t               status_next;
    logic [LENGTH_W-1:0]   length_reg;

    logic                  in_fire;
    logic                  full;
    logic                  empty;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      idx_wide;
    logic [IDX_W-1:0]      idx;
    ctl_t                  ctl;

    logic [ELEM_WIDTH+VALUE_W-1:0] value_wide;
    logic [ELEM_WIDTH-1:0]         new_elem;
    logic [ELEM_WIDTH-1:0]         removed_elem;
    logic [ELEM_WIDTH+VALUE_W-1:0] removed_wide;
    logic [CNT_W+LENGTH_W-1:0]     length_wide;

    logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
    logic [ELEM_WIDTH-1:0] cell_tap  [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign full    = (count_reg == CAP_CNT);
    assign empty   = (count_reg == '0);
    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);

    // The element keeps the low ELEM_WIDTH bits of the value field.
    assign value_wide = {{ELEM_WIDTH{1'b0}}, value};
    assign new_elem   = value_wide[ELEM_WIDTH-1:0];

    // Request decode: pick the shift command, the cell index it works on
    // and the status. Range is checked before fullness for insert at.
    always_comb
    begin
        ctl         = '0;
        idx_wide    = '0;
        status_next = ST_OK;
        unique case (action_t'(action))
            ACT_ADD_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_OVER;
                end
                else
                begin
                    ctl.shift_ins = 1'b1;
                end
            end
            ACT_ADD_REAR:
            begin
                idx_wide = cnt_ext;
                if (full)
                begin
                    status_next = ST_OVER;
                end
                else
                begin
                    ctl.shift_ins = 1'b1;
                end
            end
            ACT_REMOVE_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_UNDER;
                end
                else
                begin
                    ctl.shift_del = 1'b1;
                end
            end
            ACT_REMOVE_REAR:
            begin
                idx_wide = cnt_ext - 1'b1;
                if (empty)
                begin
                    status_next = ST_UNDER;
                end
                else
                begin
                    ctl.shift_del = 1'b1;
                end
            end
            ACT_INSERT_AT:
            begin
                idx_wide = pos_ext - 1'b1;
                if ((pos_ext == '0) || (pos_ext > cnt_ext + 1'b1))
                begin
                    status_next = ST_RANGE;
                end
                else if (full)
                begin
                    status_next = ST_OVER;
                end
                else
                begin
                    ctl.shift_ins = 1'b1;
                end
            end
            ACT_REMOVE_AT:
            begin
                idx_wide = pos_ext - 1'b1;
                if ((pos_ext == '0) || (pos_ext > cnt_ext))
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    ctl.shift_del = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase
        // Nothing moves unless a beat is taken this cycle.
        if (!in_fire)
        begin
            ctl = '0;
        end
    end

    // When a shift is issued, idx_wide is below CAPACITY, so the low bits
    // address the cell exactly.
    assign idx = idx_wide[IDX_W-1:0];

    // The row of cells. Cell zero holds the front of the list.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ELEM_WIDTH-1:0] left_data;
        logic [ELEM_WIDTH-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_right
            assign right_data = cell_data[i+1];
        end

        plc_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .IDX_W      (IDX_W),
            .CELL_INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .idx        (idx),
            .new_elem   (new_elem),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    // At most one cell drives its tap, so an OR across the row picks out
    // the element being removed, and gives zero for every other request.
    always_comb
    begin
        removed_elem = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            removed_elem = removed_elem | cell_tap[k];
        end
    end

    assign removed_wide = {{VALUE_W{1'b0}}, removed_elem};

    always_comb
    begin
        count_next = count_reg;
        if (ctl.shift_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.shift_del)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign length_wide = {{LENGTH_W{1'b0}}, count_next};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    // Result payload is loaded only when a beat is taken.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            removed_reg <= removed_wide[VALUE_W-1:0];
            status_reg  <= status_next;
            length_reg  <= length_wide[LENGTH_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign length        = length_reg;

    // The count never goes past the capacity of the row.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("list count exceeds capacity");

    // A successful add or insert grows the list by exactly one.
    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift_ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the count by one");

    // A failed request leaves the count as it was.
    a_fail_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !ctl.shift_ins && !ctl.shift_del |=> $stable(count_reg))
        else $error("failed request changed the count");

    // Only a successful removal reports a nonzero element.
    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !ctl.shift_del |=> removed_reg == '0)
        else $error("removed element reported without a removal");

    // A request with status other than ok never moves the row.
    a_status_ctl: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (status_next != ST_OK) |-> !ctl.shift_ins && !ctl.shift_del)
        else $error("failing request issued a shift");

endmodule

`default_nettype wire
